// File: src/circular_linked_queue_manager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular linked queue manager
// Short forms for the concurrent checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_QUEUE_MANAGER_ASSERT_SVH
`define CIRCULAR_LINKED_QUEUE_MANAGER_ASSERT_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define CLQM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define CLQM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// The expression must never be true, outside reset.
`define CLQM_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

// File: src/clqm_pkg.sv
// ----------------------------------------------------------------------------
// clqm_pkg
// Sizes, types, command codes and helpers of the circular linked queue manager.
// ----------------------------------------------------------------------------
package clqm_pkg;

    // Pool and list counts.
    localparam int NODES  = 64;
    localparam int LISTS  = 4;

    // Fixed widths of the request and response fields.
    localparam int CMD_W     = 2;
    localparam int LIST_ID_W = 2;
    localparam int NODE_ID_W = 6;

    // Internal index widths.
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LIST_W-1:0] list_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_REM  = 2'd2,
        CMD_FIND = 2'd3
    } cmd_t;

    // Keeps a stored link inside the node pool.
    function automatic node_t clampn(input node_t v);
        return (32'(v) < NODES) ? v : '0;
    endfunction

endpackage

// File: src/circular_linked_queue_manager.sv
// Response: each request runs through the states of its command and ends in FIN, where it
// loads the output register; a find first walks the ring link by link. A response still
// waiting in the output register holds the next one back in FIN.
// Throughput: one request at a time; the find walk reads one next link per cycle from the
// next-link memory.
// Reset: every list is empty, every head index is zero and the link memories are not cleared.
// ----------------------------------------------------------------------------
// circular_linked_queue_manager
// Several circular doubly linked lists sharing one node pool, with the next and
// previous links held in two single-port-read memories and a small sequencer.
// ----------------------------------------------------------------------------
`include "circular_linked_queue_manager_assert.svh"

module circular_linked_queue_manager
    import clqm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [LIST_ID_W-1:0] s_list_id,
    input  logic [NODE_ID_W-1:0] s_node,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [NODE_ID_W-1:0] m_out_node,
    output logic                 m_was_empty,
    output logic                 m_found
);

    // The sequencer takes one request in IDLE, walks through the memory
    // accesses of its command, and parks the response in FIN until the
    // output register is free. A new request can be taken while the
    // previous response still waits on the m_ channel.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ0,
        ST_ENQ1,
        ST_ENQ2,
        ST_DEQ0,
        ST_DEQ1,
        ST_REM0,
        ST_REM1,
        ST_FIND0,
        ST_FWALK,
        ST_FIN
    } state_t;

    state_t    state_reg, state_next;
    cmd_t      cmd_reg, cmd_next;
    list_idx_t list_reg, list_next;
    node_t     node_reg, node_next;
    logic      node_ok_reg, node_ok_next;
    node_t     step_reg, step_next;

    // List heads live in flip-flops: there are only a few of them, and
    // every command but remove needs its list's head in the first cycle.
    node_t     head_index_reg [LISTS];
    node_t     head_index_next[LISTS];
    logic      head_valid_reg [LISTS];
    logic      head_valid_next[LISTS];

    // Response being built, and the output register.
    node_t     res_node_reg, res_node_next;
    logic      res_empty_reg, res_empty_next;
    logic      res_found_reg, res_found_next;

    logic                 m_valid_reg, m_valid_next;
    logic [NODE_ID_W-1:0] m_out_node_reg, m_out_node_next;
    logic                 m_was_empty_reg, m_was_empty_next;
    logic                 m_found_reg, m_found_next;

    // Link memories. Both share one read address; each has its own write port.
    node_t next_mem [NODES];
    node_t prev_mem [NODES];
    node_t nrd_reg;
    node_t prd_reg;

    logic  rd_en;
    node_t rd_addr;
    logic  nw_en;
    node_t nw_addr;
    node_t nw_data;
    logic  pw_en;
    node_t pw_addr;
    node_t pw_data;

    logic  in_list_ok;
    logic  in_node_ok;
    logic  out_free;
    node_t h_cur;
    logic  hv_cur;
    node_t nx;
    node_t px;

    assign in_list_ok = (32'(s_list_id) < LISTS);
    assign in_node_ok = (32'(s_node) < NODES);
    assign out_free   = !m_valid_reg || m_ready;

    // Head of the list under work and the links read in the previous cycle.
    assign h_cur  = clampn(head_index_reg[list_reg]);
    assign hv_cur = head_valid_reg[list_reg];
    assign nx     = clampn(nrd_reg);
    assign px     = clampn(prd_reg);

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_out_node  = m_out_node_reg;
    assign m_was_empty = m_was_empty_reg;
    assign m_found     = m_found_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        list_next       = list_reg;
        node_next       = node_reg;
        node_ok_next    = node_ok_reg;
        step_next       = step_reg;
        head_index_next = head_index_reg;
        head_valid_next = head_valid_reg;
        res_node_next   = res_node_reg;
        res_empty_next  = res_empty_reg;
        res_found_next  = res_found_reg;

        m_valid_next     = m_valid_reg && !m_ready;
        m_out_node_next  = m_out_node_reg;
        m_was_empty_next = m_was_empty_reg;
        m_found_next     = m_found_reg;

        rd_en   = 1'b0;
        rd_addr = '0;
        nw_en   = 1'b0;
        nw_addr = '0;
        nw_data = '0;
        pw_en   = 1'b0;
        pw_addr = '0;
        pw_data = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = cmd_t'(s_cmd);
                    list_next      = list_idx_t'(s_list_id);
                    node_next      = node_t'(s_node);
                    node_ok_next   = in_node_ok;
                    res_node_next  = '0;
                    res_empty_next = 1'b0;
                    res_found_next = 1'b0;
                    if (!in_list_ok) begin
                        // A list beyond the configured count is ignored.
                        state_next = ST_FIN;
                    end else begin
                        unique case (cmd_t'(s_cmd))
                            CMD_ENQ:  state_next = ST_ENQ0;
                            CMD_DEQ:  state_next = ST_DEQ0;
                            CMD_REM:  state_next = ST_REM0;
                            CMD_FIND: state_next = ST_FIND0;
                            default:  state_next = ST_FIN;
                        endcase
                    end
                end
            end

            ST_ENQ0: begin
                if (!node_ok_reg) begin
                    state_next = ST_FIN;
                end else if (!hv_cur) begin
                    // First node of an empty list links to itself.
                    nw_en   = 1'b1;
                    nw_addr = node_reg;
                    nw_data = node_reg;
                    pw_en   = 1'b1;
                    pw_addr = node_reg;
                    pw_data = node_reg;
                    head_index_next[list_reg] = node_reg;
                    head_valid_next[list_reg] = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    // Fetch the tail, which is the head's previous link.
                    rd_en      = 1'b1;
                    rd_addr    = h_cur;
                    state_next = ST_ENQ1;
                end
            end

            ST_ENQ1: begin
                // tail.next = node, node.prev = tail
                nw_en      = 1'b1;
                nw_addr    = px;
                nw_data    = node_reg;
                pw_en      = 1'b1;
                pw_addr    = node_reg;
                pw_data    = px;
                state_next = ST_ENQ2;
            end

            ST_ENQ2: begin
                // node.next = head, head.prev = node; written after the
                // tail update so that aliased entries end as in sequence.
                nw_en      = 1'b1;
                nw_addr    = node_reg;
                nw_data    = h_cur;
                pw_en      = 1'b1;
                pw_addr    = h_cur;
                pw_data    = node_reg;
                state_next = ST_FIN;
            end

            ST_DEQ0: begin
                if (!hv_cur) begin
                    res_empty_next = 1'b1;
                    state_next     = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = h_cur;
                    state_next = ST_DEQ1;
                end
            end

            ST_DEQ1: begin
                res_node_next = h_cur;
                if (nx == h_cur) begin
                    head_valid_next[list_reg] = 1'b0;
                end else begin
                    pw_en   = 1'b1;
                    pw_addr = nx;
                    pw_data = px;
                    nw_en   = 1'b1;
                    nw_addr = px;
                    nw_data = nx;
                    head_index_next[list_reg] = nx;
                end
                state_next = ST_FIN;
            end

            ST_REM0: begin
                if (!node_ok_reg) begin
                    state_next = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = node_reg;
                    state_next = ST_REM1;
                end
            end

            ST_REM1: begin
                if (hv_cur && (h_cur == node_reg) && (nx == node_reg)) begin
                    // Removing the only node empties the list, links untouched.
                    head_valid_next[list_reg] = 1'b0;
                end else begin
                    if (hv_cur && (h_cur == node_reg)) begin
                        head_index_next[list_reg] = nx;
                    end
                    pw_en   = 1'b1;
                    pw_addr = nx;
                    pw_data = px;
                    nw_en   = 1'b1;
                    nw_addr = px;
                    nw_data = nx;
                end
                state_next = ST_FIN;
            end

            ST_FIND0: begin
                if (!hv_cur) begin
                    res_empty_next = 1'b1;
                    state_next     = ST_FIN;
                end else if (!node_ok_reg) begin
                    state_next = ST_FIN;
                end else if (h_cur == node_reg) begin
                    res_found_next = 1'b1;
                    state_next     = ST_FIN;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = h_cur;
                    step_next  = '0;
                    state_next = ST_FWALK;
                end
            end

            ST_FWALK: begin
                // One link per cycle: the read data addresses the next read.
                if (nx == h_cur) begin
                    state_next = ST_FIN;
                end else if (step_reg == node_t'(NODES - 1)) begin
                    // Broken ring: give up after a full pool of steps.
                    state_next = ST_FIN;
                end else if (nx == node_reg) begin
                    res_found_next = 1'b1;
                    state_next     = ST_FIN;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = nx;
                    step_next = step_reg + node_t'(1);
                end
            end

            ST_FIN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_out_node_next  = NODE_ID_W'(res_node_reg);
                    m_was_empty_next = res_empty_reg;
                    m_found_next     = res_found_reg;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state, request fields, list heads, response and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                head_index_reg[i] <= '0;
                head_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            head_index_reg <= head_index_next;
            head_valid_reg <= head_valid_next;
        end
        cmd_reg         <= cmd_next;
        list_reg        <= list_next;
        node_reg        <= node_next;
        node_ok_reg     <= node_ok_next;
        step_reg        <= step_next;
        res_node_reg    <= res_node_next;
        res_empty_reg   <= res_empty_next;
        res_found_reg   <= res_found_next;
        m_out_node_reg  <= m_out_node_next;
        m_was_empty_reg <= m_was_empty_next;
        m_found_reg     <= m_found_next;
    end

    // Next-link memory.
    always_ff @(posedge aclk) begin
        if (nw_en) begin
            next_mem[nw_addr] <= nw_data;
        end
        if (rd_en) begin
            nrd_reg <= next_mem[rd_addr];
        end
    end

    // Previous-link memory.
    always_ff @(posedge aclk) begin
        if (pw_en) begin
            prev_mem[pw_addr] <= pw_data;
        end
        if (rd_en) begin
            prd_reg <= prev_mem[rd_addr];
        end
    end

    // The sequencer never reads a link memory in a cycle that writes one.
    `CLQM_ASSERT_NEVER(a_no_rd_wr_overlap, rd_en && (nw_en || pw_en), "link read during write")
    // A taken request closes the request channel in the cycle after it.
    `CLQM_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second request taken")
    // A new response is only ever loaded from the finishing state.
    `CLQM_ASSERT_IMP(a_resp_from_fin, $rose(m_valid_reg), $past(state_reg) == ST_FIN,
        "response loaded outside FIN")
    // A response never reports both an empty list and a hit.
    `CLQM_ASSERT_NEVER(a_found_not_empty, m_valid && m_found && m_was_empty,
        "found on an empty list")

endmodule
